FILE: rtl/core/cbc_pkg.sv
// Shared types, constants and helpers for the circle bounce collision step.
// Used by cbc_cell and circle_bounce_collision_step; no dependencies.
package cbc_pkg;

	localparam int NUM_OBSTACLES = 4;
	localparam int FRAC_BITS     = 12;
	localparam int NCELL         = NUM_OBSTACLES + 4;
	localparam int RSH           = FRAC_BITS - 8;
	localparam int RW            = 16 + RSH;
	localparam int QB            = 26;
	localparam logic [22:0] WORLD_RESET = 23'(100 << FRAC_BITS);
	localparam logic signed [24:0] ONE  = 25'(1 << FRAC_BITS);

	localparam logic [2:0] REG_OBS0   = 3'd0;
	localparam logic [2:0] REG_OBS1   = 3'd1;
	localparam logic [2:0] REG_OBS2   = 3'd2;
	localparam logic [2:0] REG_OBS3   = 3'd3;
	localparam logic [2:0] REG_ENABLE = 3'd4;
	localparam logic [2:0] REG_WIDTH  = 3'd5;
	localparam logic [2:0] REG_HEIGHT = 3'd6;

	typedef struct packed {
		logic [23:0]   px;
		logic [23:0]   py;
		logic [23:0]   vx;
		logic [23:0]   vy;
		logic [RW-1:0] r;
		logic [7:0]    mask;
	} cbc_item_t;

	typedef struct packed {
		logic [24:0]   x0;
		logic [24:0]   y0;
		logic [24:0]   x1;
		logic [24:0]   y1;
		logic [RW-1:0] orad;
		logic          en;
		logic [7:0]    hit_bit;
	} cbc_geom_t;

	function automatic logic [23:0] sat24(input logic signed [27:0] v);
		if (v > 28'sd8388607) return 24'h7FFFFF;
		if (v < -28'sd8388608) return 24'h800000;
		return v[23:0];
	endfunction

	function automatic logic signed [24:0] clamp25(input logic signed [24:0] p,
			input logic signed [24:0] lo, input logic signed [24:0] hi);
		logic signed [24:0] t;
		t = (p < lo) ? lo : p;
		t = (t > hi) ? hi : t;
		return t;
	endfunction

endpackage

FILE: rtl/core/cbc_cell.sv
// One test cell: hit test against a box (a point for an obstacle) and
// velocity reflection with a bit-serial divider. Depends on cbc_pkg.
module cbc_cell import cbc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cbc_geom_t geom,
	input  logic      in_valid,
	output logic      in_ready,
	input  cbc_item_t in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output cbc_item_t out_item
);

	typedef enum logic [10:0] {
		S_IDLE = 11'h001, S_DIFF = 11'h002, S_SQ  = 11'h004, S_CMP  = 11'h008,
		S_DOT  = 11'h010, S_SUM  = 11'h020, S_MUL = 11'h040, S_PREP = 11'h080,
		S_DIV  = 11'h100, S_UPD  = 11'h200, S_DONE = 11'h400
	} cell_state_t;

	cell_state_t state_q;
	cbc_item_t   item_q;
	logic signed [24:0] dx_q, dy_q;
	logic [48:0] dxx_q, dyy_q;
	logic [2*RW+1:0] rr_q;
	logic signed [15:0] dxs_q, dys_q;
	logic [14:0] axs_q, ays_q;
	logic signed [39:0] p1_q, p2_q;
	logic [30:0] den_q;
	logic signed [40:0] dot_q;
	logic signed [56:0] nx_q, ny_q;
	logic [30:0] remx_q, remy_q;
	logic [QB-1:0] qx_q, qy_q;
	logic negx_q, negy_q;
	logic [4:0] cnt_q;

	logic signed [24:0] pxe, pye, cx, cy;
	logic signed [25:0] dxw, dyw;
	logic signed [49:0] sqx, sqy;
	logic [RW:0] rs;
	logic [2*RW+1:0] rr;
	logic hit, nz;
	logic [24:0] ax, ay, m;
	logic [3:0] sh;
	logic [14:0] axs, ays;
	logic signed [39:0] p1, p2;
	logic signed [56:0] nx, ny;
	logic [57:0] tx, ty, absx, absy;
	logic [58:0] magx, magy;
	logic [31:0] tdx, tdy;
	logic gex, gey;
	logic [27:0] qsx, qsy;
	logic [23:0] vxn, vyn;

	always_comb begin
		pxe = {item_q.px[23], item_q.px};
		pye = {item_q.py[23], item_q.py};
		cx  = clamp25(pxe, geom.x0, geom.x1);
		cy  = clamp25(pye, geom.y0, geom.y1);
		dxw = {pxe[24], pxe} - {cx[24], cx};
		dyw = {pye[24], pye} - {cy[24], cy};
		sqx = dx_q * dx_q;
		sqy = dy_q * dy_q;
		rs  = {1'b0, item_q.r} + {1'b0, geom.orad};
		rr  = rs * rs;
		hit = ({1'b0, dxx_q} + {1'b0, dyy_q}) < {{(48-2*RW){1'b0}}, rr_q};
		nz  = (dx_q != '0) || (dy_q != '0);
		ax  = dx_q[24] ? 25'(-dx_q) : 25'(dx_q);
		ay  = dy_q[24] ? 25'(-dy_q) : 25'(dy_q);
		m   = (ax > ay) ? ax : ay;
		sh  = '0;
		for (int k = 0; k < 11; k++) begin
			if ((m >> k) >= 25'd32768) sh = 4'(k + 1);
		end
		axs = 15'(ax >> sh);
		ays = 15'(ay >> sh);
		p1  = $signed(item_q.vx) * dxs_q;
		p2  = $signed(item_q.vy) * dys_q;
		nx  = dot_q * dxs_q;
		ny  = dot_q * dys_q;
		tx  = {nx_q, 1'b0};
		ty  = {ny_q, 1'b0};
		absx = nx_q[56] ? -tx : tx;
		absy = ny_q[56] ? -ty : ty;
		magx = {1'b0, absx} + 59'(den_q >> 1);
		magy = {1'b0, absy} + 59'(den_q >> 1);
		tdx = {remx_q, qx_q[QB-1]};
		tdy = {remy_q, qy_q[QB-1]};
		gex = tdx >= {1'b0, den_q};
		gey = tdy >= {1'b0, den_q};
		qsx = negx_q ? -{2'b0, qx_q} : {2'b0, qx_q};
		qsy = negy_q ? -{2'b0, qy_q} : {2'b0, qy_q};
		vxn = sat24($signed({{4{item_q.vx[23]}}, item_q.vx} - qsx));
		vyn = sat24($signed({{4{item_q.vy[23]}}, item_q.vy} - qsy));
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_DONE);
	assign out_item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= geom.en ? S_DIFF : S_DONE;
				S_DIFF: state_q <= S_SQ;
				S_SQ:   state_q <= S_CMP;
				S_CMP:  state_q <= (hit && nz) ? S_DOT : S_DONE;
				S_DOT:  state_q <= S_SUM;
				S_SUM:  state_q <= S_MUL;
				S_MUL:  state_q <= S_PREP;
				S_PREP: state_q <= S_DIV;
				S_DIV:  if (cnt_q == 5'(QB - 1)) state_q <= S_UPD;
				S_UPD:  state_q <= S_DONE;
				S_DONE: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (in_valid) item_q <= in_item;
			S_DIFF: begin
				dx_q <= dxw[24:0];
				dy_q <= dyw[24:0];
			end
			S_SQ: begin
				dxx_q <= sqx[48:0];
				dyy_q <= sqy[48:0];
				rr_q  <= rr;
			end
			S_CMP: begin
				axs_q <= axs;
				ays_q <= ays;
				dxs_q <= dx_q[24] ? -$signed({1'b0, axs}) : $signed({1'b0, axs});
				dys_q <= dy_q[24] ? -$signed({1'b0, ays}) : $signed({1'b0, ays});
			end
			S_DOT: begin
				p1_q  <= p1;
				p2_q  <= p2;
				den_q <= 31'(axs_q * axs_q) + 31'(ays_q * ays_q);
			end
			S_SUM: dot_q <= {p1_q[39], p1_q} + {p2_q[39], p2_q};
			S_MUL: begin
				nx_q <= nx;
				ny_q <= ny;
			end
			S_PREP: begin
				remx_q <= magx[56:QB];
				remy_q <= magy[56:QB];
				qx_q   <= magx[QB-1:0];
				qy_q   <= magy[QB-1:0];
				negx_q <= nx_q[56];
				negy_q <= ny_q[56];
				cnt_q  <= '0;
			end
			S_DIV: begin
				remx_q <= gex ? 31'(tdx - {1'b0, den_q}) : tdx[30:0];
				remy_q <= gey ? 31'(tdy - {1'b0, den_q}) : tdy[30:0];
				qx_q   <= {qx_q[QB-2:0], gex};
				qy_q   <= {qy_q[QB-2:0], gey};
				cnt_q  <= cnt_q + 5'd1;
			end
			S_UPD: begin
				item_q.vx   <= vxn;
				item_q.vy   <= vyn;
				item_q.mask <= item_q.mask | geom.hit_bit;
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/core/circle_bounce_collision_step.sv
// Top level: configuration registers, position advance and the row of test cells.
// Depends on cbc_pkg and cbc_cell.
// An item passes the advance register, then each test cell in turn, then the output register;
// a cell skips the hit test when its obstacle is disabled and runs the divider only on a reflection.
// A cell takes no new item until it has handed its last one on, and out_ready can stall every stage.
// Reset: clears all control state, obstacles and enables; world size resets to 100.0.
module circle_bounce_collision_step import cbc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [63:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [23:0] pos_x,
	input  logic [23:0] pos_y,
	input  logic [23:0] vel_x,
	input  logic [23:0] vel_y,
	input  logic [15:0] body_radius,
	input  logic [15:0] time_step,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [23:0] new_pos_x,
	output logic [23:0] new_pos_y,
	output logic [23:0] new_vel_x,
	output logic [23:0] new_vel_y,
	output logic [7:0]  bounce_mask
);

	logic [63:0] obs_q [4];
	logic [3:0]  en_q;
	logic [22:0] w_q, h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) obs_q[i] <= '0;
			en_q <= '0;
			w_q  <= WORLD_RESET;
			h_q  <= WORLD_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_OBS0, REG_OBS1, REG_OBS2, REG_OBS3: obs_q[cfg_addr[1:0]] <= cfg_wdata;
				REG_ENABLE: en_q <= cfg_wdata[3:0];
				REG_WIDTH:  w_q  <= cfg_wdata[22:0];
				REG_HEIGHT: h_q  <= cfg_wdata[22:0];
				default: ;
			endcase
		end
	end

	// advance stage
	logic adv_valid_q;
	logic signed [40:0] prodx_s1, prody_s1;
	logic [23:0] px_s1, py_s1, vx_s1, vy_s1;
	logic [15:0] r_s1;
	logic signed [41:0] rx, ry;
	logic signed [27:0] sx, sy;
	cbc_item_t adv_item;
	cbc_item_t c_in [NCELL+1];
	logic c_valid [NCELL+1];
	logic c_ready [NCELL+1];
	cbc_geom_t geoms [NCELL];
	logic [24:0] wv, hv;

	assign in_ready = !adv_valid_q || c_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adv_valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			adv_valid_q <= 1'b1;
		end else if (c_ready[0]) begin
			adv_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			prodx_s1 <= $signed(vel_x) * $signed({1'b0, time_step});
			prody_s1 <= $signed(vel_y) * $signed({1'b0, time_step});
			px_s1 <= pos_x;
			py_s1 <= pos_y;
			vx_s1 <= vel_x;
			vy_s1 <= vel_y;
			r_s1  <= body_radius;
		end
	end

	assign c_in[0]    = adv_item;
	assign c_valid[0] = adv_valid_q;

	always_comb begin
		rx = {prodx_s1[40], prodx_s1} + 42'sd32768;
		ry = {prody_s1[40], prody_s1} + 42'sd32768;
		sx = {{4{px_s1[23]}}, px_s1} + {{2{rx[41]}}, rx[41:16]};
		sy = {{4{py_s1[23]}}, py_s1} + {{2{ry[41]}}, ry[41:16]};
		adv_item.px   = sat24(sx);
		adv_item.py   = sat24(sy);
		adv_item.vx   = vx_s1;
		adv_item.vy   = vy_s1;
		adv_item.r    = RW'({r_s1, {RSH{1'b0}}});
		adv_item.mask = '0;
		wv = {2'b0, w_q};
		hv = {2'b0, h_q};
		for (int i = 0; i < NUM_OBSTACLES; i++) begin
			geoms[i].x0      = {obs_q[i][63], obs_q[i][63:40]};
			geoms[i].x1      = {obs_q[i][63], obs_q[i][63:40]};
			geoms[i].y0      = {obs_q[i][39], obs_q[i][39:16]};
			geoms[i].y1      = {obs_q[i][39], obs_q[i][39:16]};
			geoms[i].orad    = RW'({obs_q[i][15:0], {RSH{1'b0}}});
			geoms[i].en      = en_q[i];
			geoms[i].hit_bit = 8'(1 << i);
		end
		for (int k = 0; k < 4; k++) begin
			geoms[NUM_OBSTACLES+k].orad    = '0;
			geoms[NUM_OBSTACLES+k].en      = 1'b1;
			geoms[NUM_OBSTACLES+k].hit_bit = 8'(16 << k);
			geoms[NUM_OBSTACLES+k].x0      = '0;
			geoms[NUM_OBSTACLES+k].y0      = '0;
			geoms[NUM_OBSTACLES+k].x1      = wv;
			geoms[NUM_OBSTACLES+k].y1      = hv;
		end
		geoms[NUM_OBSTACLES].x1   = ONE;
		geoms[NUM_OBSTACLES+1].x0 = wv - ONE;
		geoms[NUM_OBSTACLES+2].y1 = ONE;
		geoms[NUM_OBSTACLES+3].y0 = hv - ONE;
	end

	for (genvar g = 0; g < NCELL; g++) begin : g_cell
		cbc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.geom     (geoms[g]),
			.in_valid (c_valid[g]),
			.in_ready (c_ready[g]),
			.in_item  (c_in[g]),
			.out_valid(c_valid[g+1]),
			.out_ready(c_ready[g+1]),
			.out_item (c_in[g+1])
		);
	end

	// output register
	logic      out_valid_q;
	cbc_item_t out_q;

	assign c_ready[NCELL] = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (c_ready[NCELL]) begin
			out_valid_q <= c_valid[NCELL];
		end
	end

	always_ff @(posedge clk) begin
		if (c_ready[NCELL] && c_valid[NCELL]) out_q <= c_in[NCELL];
	end

	assign out_valid   = out_valid_q;
	assign new_pos_x   = out_q.px;
	assign new_pos_y   = out_q.py;
	assign new_vel_x   = out_q.vx;
	assign new_vel_y   = out_q.vy;
	assign bounce_mask = out_q.mask;

endmodule

FILE: dv/testbench.sv
// Testbench for circle_bounce_collision_step: directed and random circle items
// checked against an in-bench fixed-point predictor. Depends on cbc_pkg and the RTL.
module testbench import cbc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int         LIMIT      = 3000000;
	localparam int         HOLD_LEN   = 600;
	localparam longint     Q          = 4096;

	typedef struct {
		logic [23:0] px;
		logic [23:0] py;
		logic [23:0] vx;
		logic [23:0] vy;
		logic [7:0]  mask;
	} motion_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_addr = '0;
	logic [63:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [23:0] pos_x = '0, pos_y = '0, vel_x = '0, vel_y = '0;
	logic [15:0] body_radius = '0, time_step = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [23:0] new_pos_x, new_pos_y, new_vel_x, new_vel_y;
	logic [7:0]  bounce_mask;

	logic [63:0] obs_shadow [4];
	logic [3:0]  enable_shadow;
	logic [22:0] width_shadow, height_shadow;

	motion_t     motion_q [$];
	int          errors = 0;
	int          cycles = 0;
	int          hold_req = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	int          stall_left = 0;
	bit          calm = 1'b0;

	circle_bounce_collision_step dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic longint clip24(input longint v);
		if (v > 8388607) return 8388607;
		if (v < -8388608) return -8388608;
		return v;
	endfunction

	function automatic longint clampl(input longint p, input longint lo, input longint hi);
		if (p < lo) p = lo;
		if (p > hi) p = hi;
		return p;
	endfunction

	function automatic longint mag(input longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint div_round(input longint num, input longint den);
		longint q;
		q = (mag(num) + den / 2) / den;
		return num < 0 ? -q : q;
	endfunction

	function automatic bit reflect(inout longint vx, inout longint vy,
			input longint dx, input longint dy);
		longint ax, ay, m, den, dot;
		int s;
		if (dx == 0 && dy == 0) return 1'b0;
		ax = mag(dx);
		ay = mag(dy);
		m = ax > ay ? ax : ay;
		s = 0;
		while ((m >>> s) >= 32768) s++;
		ax = ax >>> s;
		ay = ay >>> s;
		dx = dx < 0 ? -ax : ax;
		dy = dy < 0 ? -ay : ay;
		den = ax * ax + ay * ay;
		dot = vx * dx + vy * dy;
		vx = clip24(vx - div_round(2 * dot * dx, den));
		vy = clip24(vy - div_round(2 * dot * dy, den));
		return 1'b1;
	endfunction

	function automatic bit wall_bounce(input longint px, input longint py, input longint r,
			input longint x0, input longint y0, input longint x1, input longint y1,
			inout longint vx, inout longint vy);
		longint dx, dy;
		dx = px - clampl(px, x0, x1);
		dy = py - clampl(py, y0, y1);
		if (dx * dx + dy * dy < r * r) return reflect(vx, vy, dx, dy);
		return 1'b0;
	endfunction

	function automatic motion_t predict_motion(input logic [23:0] ipx, ipy, ivx, ivy,
			input logic [15:0] rad, dt);
		motion_t res;
		longint px, py, vx, vy, r, w, h, one, ox, oy, dx, dy, rs;
		logic [7:0] m;
		px = longint'($signed(ipx));
		py = longint'($signed(ipy));
		vx = longint'($signed(ivx));
		vy = longint'($signed(ivy));
		r = longint'(rad) <<< RSH;
		one = longint'(1) <<< FRAC_BITS;
		w = longint'(width_shadow);
		h = longint'(height_shadow);
		m = '0;
		px = clip24(px + ((vx * longint'(dt) + 32768) >>> 16));
		py = clip24(py + ((vy * longint'(dt) + 32768) >>> 16));
		for (int i = 0; i < NUM_OBSTACLES; i++) begin
			if (enable_shadow[i]) begin
				ox = longint'($signed(obs_shadow[i][63:40]));
				oy = longint'($signed(obs_shadow[i][39:16]));
				rs = r + (longint'(obs_shadow[i][15:0]) <<< RSH);
				dx = px - ox;
				dy = py - oy;
				if (dx * dx + dy * dy < rs * rs && reflect(vx, vy, dx, dy)) m[i] = 1'b1;
			end
		end
		if (wall_bounce(px, py, r, 0, 0, one, h, vx, vy)) m[4] = 1'b1;
		if (wall_bounce(px, py, r, w - one, 0, w, h, vx, vy)) m[5] = 1'b1;
		if (wall_bounce(px, py, r, 0, 0, w, one, vx, vy)) m[6] = 1'b1;
		if (wall_bounce(px, py, r, 0, h - one, w, h, vx, vy)) m[7] = 1'b1;
		res.px = px[23:0];
		res.py = py[23:0];
		res.vx = vx[23:0];
		res.vy = vy[23:0];
		res.mask = m;
		return res;
	endfunction

	// result side: check, then decide next ready
	always @(posedge clk) begin
		motion_t e;
		if (out_valid && out_ready) begin
			if (motion_q.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				e = motion_q.pop_front();
				if (new_pos_x !== e.px) begin
					$error("new_pos_x exp %h got %h", e.px, new_pos_x);
					errors++;
				end
				if (new_pos_y !== e.py) begin
					$error("new_pos_y exp %h got %h", e.py, new_pos_y);
					errors++;
				end
				if (new_vel_x !== e.vx) begin
					$error("new_vel_x exp %h got %h", e.vx, new_vel_x);
					errors++;
				end
				if (new_vel_y !== e.vy) begin
					$error("new_vel_y exp %h got %h", e.vy, new_vel_y);
					errors++;
				end
				if (bounce_mask !== e.mask) begin
					$error("bounce_mask exp %h got %h", e.mask, bounce_mask);
					errors++;
				end
			end
		end
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 17) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		if (idx <= REG_OBS3) obs_shadow[idx] = val;
		else if (idx == REG_ENABLE) enable_shadow = val[3:0];
		else if (idx == REG_WIDTH) width_shadow = val[22:0];
		else if (idx == REG_HEIGHT) height_shadow = val[22:0];
		@(posedge clk);
	endtask

	task automatic end_writes();
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [63:0] obstacle(input longint x, input longint y,
			input logic [15:0] r);
		return {x[23:0], y[23:0], r};
	endfunction

	task automatic send_item(input logic [23:0] px, py, vx, vy, input logic [15:0] r, dt);
		if (!calm && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		pos_x <= px;
		pos_y <= py;
		vel_x <= vx;
		vel_y <= vy;
		body_radius <= r;
		time_step <= dt;
		do @(posedge clk); while (!in_ready);
		motion_q.insert(motion_q.size(), predict_motion(px, py, vx, vy, r, dt));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (motion_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic test_walls();
		send_item(50 * Q, 50 * Q, 3 * Q, -2 * Q, 16'd512, 16'h8000);
		send_item(Q + Q / 2, 50 * Q, -10 * Q, Q, 16'd256, 16'd0);
		send_item(98 * Q + Q / 2, 50 * Q, 10 * Q, Q, 16'd256, 16'd0);
		send_item(50 * Q, Q + Q / 2, Q, -10 * Q, 16'd256, 16'd0);
		send_item(50 * Q, 98 * Q + Q / 2, Q, 10 * Q, 16'd256, 16'd0);
		send_item(Q + Q / 2, Q + Q / 2, -5 * Q, -5 * Q, 16'd512, 16'd100);
		send_item(Q / 2, 50 * Q, -3 * Q, 2 * Q, 16'd256, 16'd0);
		send_item(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'd0, 16'hFFFF);
		send_item(24'h800000, 24'h800000, 24'h800000, 24'h800000, 16'd0, 16'hFFFF);
		send_item(50 * Q, 50 * Q, 24'h7FFFFF, 24'h800000, 16'hFFFF, 16'd0);
		send_item(20 * Q, 60 * Q, 0, 0, 16'd256, 16'd0);
		drain();
	endtask

	task automatic test_obstacles();
		write_reg(REG_OBS0, obstacle(30 * Q, 30 * Q, 16'd1280));
		write_reg(REG_OBS1, obstacle(70 * Q, 30 * Q, 16'd0));
		write_reg(REG_OBS2, obstacle(30 * Q, 70 * Q, 16'hFFFF));
		write_reg(REG_OBS3, obstacle(-8388608, 8388607, 16'd0));
		write_reg(REG_ENABLE, 64'hF);
		write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
		end_writes();
		send_item(33 * Q, 31 * Q, -4 * Q, Q, 16'd256, 16'd0);
		send_item(30 * Q, 30 * Q, Q, Q, 16'd256, 16'd0);
		send_item(71 * Q, 30 * Q, -2 * Q, 3 * Q, 16'd768, 16'd0);
		send_item(24'h800000, 24'h7FFFFF, 5 * Q, -7 * Q, 16'd512, 16'd0);
		send_item(60 * Q, 60 * Q, 9 * Q, 4 * Q, 16'd1024, 16'h4000);
		drain();
		write_reg(REG_ENABLE, 64'h0);
		write_reg(REG_WIDTH, 64'h0);
		write_reg(REG_HEIGHT, 64'h0);
		end_writes();
		send_item(Q / 4, Q / 3, 2 * Q, -Q, 16'd512, 16'd0);
		drain();
		write_reg(REG_WIDTH, 64'h7FFFFF);
		write_reg(REG_HEIGHT, 64'h7FFFFF);
		end_writes();
		send_item(24'h7FFFFF, 24'h7FFFFF, Q, Q, 16'hFFFF, 16'd0);
		send_item(1000 * Q, 1000 * Q, Q, -Q, 16'd256, 16'd0);
		drain();
	endtask

	task automatic test_random(input int n, input bit wild_world);
		logic [23:0] px, py, vx, vy;
		logic [15:0] r;
		longint w, h;
		for (int i = 0; i < 4; i++)
			write_reg(REG_OBS0 + 3'(i), obstacle($urandom_range(0, 100 * Q),
				$urandom_range(0, 100 * Q), 16'($urandom_range(0, 2048))));
		write_reg(REG_ENABLE, 64'($urandom_range(0, 15)));
		w = wild_world ? $urandom_range(0, 23'h7FFFFF) : $urandom_range(20 * Q, 200 * Q);
		h = wild_world ? $urandom_range(0, 23'h7FFFFF) : $urandom_range(20 * Q, 200 * Q);
		write_reg(REG_WIDTH, 64'(w));
		write_reg(REG_HEIGHT, 64'(h));
		end_writes();
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 4) == 0) begin
				send_item(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
					16'($urandom), 16'($urandom));
			end else begin
				px = 24'($urandom_range(0, 32'(width_shadow)));
				py = 24'($urandom_range(0, 32'(height_shadow)));
				vx = 24'(int'($urandom_range(0, 80 * Q)) - 40 * Q);
				vy = 24'(int'($urandom_range(0, 80 * Q)) - 40 * Q);
				r = 16'($urandom_range(0, 1536));
				send_item(px, py, vx, vy, r, 16'($urandom));
			end
		end
		drain();
	endtask

	task automatic test_backpressure();
		hold_req++;
		for (int k = 0; k < 80; k++)
			send_item(24'($urandom_range(0, 100 * Q)), 24'($urandom_range(0, 100 * Q)),
				24'($urandom), 24'($urandom), 16'($urandom_range(0, 1024)), 16'($urandom));
		drain();
	endtask

	initial begin
		for (int i = 0; i < 4; i++) obs_shadow[i] = '0;
		enable_shadow = '0;
		width_shadow = WORLD_RESET;
		height_shadow = WORLD_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_walls();
		test_obstacles();
		for (int p = 0; p < 8; p++) test_random(200, p % 4 == 3);
		test_backpressure();
		calm = 1'b1;
		test_random(200, 1'b0);
		if (errors == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/cbc_pkg.sv
rtl/core/cbc_cell.sv
rtl/core/circle_bounce_collision_step.sv
dv/testbench.sv
